### hw/rtl/sgrg_pkg.sv
// Shared constants, types and glyph tables of the scaled glyph rectangle generator.
`default_nettype none

package sgrg_pkg;

	// Fixed field widths
	localparam int CODE_W  = 8;
	localparam int COORD_W = 12;
	localparam int SCALE_W = 4;
	localparam int COLOR_W = 16;

	// Default internal coordinate width (wrap point of all coordinate sums)
	localparam int COORD_BITS_DEF = 12;

	// Glyph cell geometry
	localparam int GLYPH_ROWS = 7;
	localparam int GLYPH_COLS = 5;
	localparam int CELL_PITCH = GLYPH_COLS + 1;
	localparam int ROW_IDX_W  = $clog2(GLYPH_ROWS);
	localparam int COL_IDX_W  = $clog2(GLYPH_COLS);
	localparam int OFS_W      = 7;
	localparam int GLYPH_IDX_W = 5;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SCALE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DRAW_COLOR  = 1'd1;

	// Register reset values
	localparam logic [SCALE_W-1:0] SCALE_RST = 4'd1;
	localparam logic [COLOR_W-1:0] COLOR_RST = 16'hFFFF;

	// Glyph index codes
	localparam logic [GLYPH_IDX_W-1:0] GI_BLANK  = 5'd0;
	localparam logic [GLYPH_IDX_W-1:0] GI_DIGIT0 = 5'd1;
	localparam logic [GLYPH_IDX_W-1:0] GI_A      = 5'd11;
	localparam logic [GLYPH_IDX_W-1:0] GI_B      = 5'd12;
	localparam logic [GLYPH_IDX_W-1:0] GI_C      = 5'd13;
	localparam logic [GLYPH_IDX_W-1:0] GI_D      = 5'd14;
	localparam logic [GLYPH_IDX_W-1:0] GI_E      = 5'd15;
	localparam logic [GLYPH_IDX_W-1:0] GI_H      = 5'd16;
	localparam logic [GLYPH_IDX_W-1:0] GI_I      = 5'd17;
	localparam logic [GLYPH_IDX_W-1:0] GI_K      = 5'd18;
	localparam logic [GLYPH_IDX_W-1:0] GI_N      = 5'd19;
	localparam logic [GLYPH_IDX_W-1:0] GI_R      = 5'd20;
	localparam logic [GLYPH_IDX_W-1:0] GI_S      = 5'd21;
	localparam logic [GLYPH_IDX_W-1:0] GI_U      = 5'd22;
	localparam logic [GLYPH_IDX_W-1:0] GI_COLON  = 5'd23;
	localparam logic [GLYPH_IDX_W-1:0] GI_LPAREN = 5'd24;
	localparam logic [GLYPH_IDX_W-1:0] GI_RPAREN = 5'd25;

	// One glyph: row 0 on top, bit 4 of a row is the leftmost dot
	typedef logic [GLYPH_ROWS-1:0][GLYPH_COLS-1:0] glyph_t;

	// Map a character code onto its glyph index
	function automatic logic [GLYPH_IDX_W-1:0] glyph_index(input logic [CODE_W-1:0] code);
		logic [GLYPH_IDX_W-1:0] idx;
		idx = GI_BLANK;
		if (code >= "0" && code <= "9") begin
			idx = GI_DIGIT0 + GLYPH_IDX_W'(code - "0");
		end else begin
			case (code)
				"A":      idx = GI_A;
				"B":      idx = GI_B;
				"C", "c": idx = GI_C;
				"D":      idx = GI_D;
				"E":      idx = GI_E;
				"H":      idx = GI_H;
				"I":      idx = GI_I;
				"K":      idx = GI_K;
				"N":      idx = GI_N;
				"R":      idx = GI_R;
				"S":      idx = GI_S;
				"U":      idx = GI_U;
				":":      idx = GI_COLON;
				"(":      idx = GI_LPAREN;
				")":      idx = GI_RPAREN;
				default:  idx = GI_BLANK;
			endcase
		end
		return idx;
	endfunction

	// Glyph table, rows listed bottom (row 6) to top (row 0)
	function automatic glyph_t glyph_rom(input logic [GLYPH_IDX_W-1:0] idx);
		glyph_t g;
		case (idx)
			5'd1:    g = {5'h0E, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h0E};
			5'd2:    g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0C, 5'h04};
			5'd3:    g = {5'h1F, 5'h08, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
			5'd4:    g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h02, 5'h1F};
			5'd5:    g = {5'h02, 5'h02, 5'h1F, 5'h12, 5'h0A, 5'h06, 5'h02};
			5'd6:    g = {5'h0E, 5'h11, 5'h01, 5'h01, 5'h1E, 5'h10, 5'h1F};
			5'd7:    g = {5'h0E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h08, 5'h06};
			5'd8:    g = {5'h08, 5'h08, 5'h08, 5'h04, 5'h02, 5'h01, 5'h1F};
			5'd9:    g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
			5'd10:   g = {5'h0C, 5'h02, 5'h01, 5'h0F, 5'h11, 5'h11, 5'h0E};
			5'd11:   g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h0E};
			5'd12:   g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
			5'd13:   g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
			5'd14:   g = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
			5'd15:   g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
			5'd16:   g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
			5'd17:   g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
			5'd18:   g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
			5'd19:   g = {5'h11, 5'h11, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11};
			5'd20:   g = {5'h11, 5'h12, 5'h14, 5'h1E, 5'h11, 5'h11, 5'h1E};
			5'd21:   g = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h10, 5'h10, 5'h0F};
			5'd22:   g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11};
			5'd23:   g = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
			5'd24:   g = {5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02};
			5'd25:   g = {5'h08, 5'h04, 5'h02, 5'h02, 5'h02, 5'h04, 5'h08};
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/scaled_glyph_rect_generator.sv
// Top level: character requests in, one filled-square request per set glyph dot out.
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+--------------------------------------------
//  in        | input     | in_valid/in_stall  | char_code, restart, start_x, start_y
//  out       | output    | out_valid/out_stall| rect_left/top/right/bottom, rect_color, last
//  cfg       | input     | cfg_we             | cfg_index, cfg_data
//
// A character is registered in the input stage (glyph table read), then the dot
// scanner emits one square per cycle unless the output is stalled; a blank emits none.
// The scanner sets the rate; the next character is loaded as the last dot leaves.
// The pen lives in a one-entry memory, read every cycle with write forwarding.
// Reset clears the pen to the origin, scale to 1 and colour to white.
// out_stall freezes the scanner and the output register; in_stall follows.
`default_nettype none

module scaled_glyph_rect_generator #(
	parameter int COORD_BITS = sgrg_pkg::COORD_BITS_DEF
) (
	input  wire  logic                                  clk,
	input  wire  logic                                  arst_n,
	// configuration
	input  wire  logic                                  cfg_we,
	input  wire  logic [sgrg_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire  logic [sgrg_pkg::COLOR_W-1:0]          cfg_data,
	// character requests
	input  wire  logic                                  in_valid,
	output logic                                        in_stall,
	input  wire  logic [sgrg_pkg::CODE_W-1:0]           char_code,
	input  wire  logic                                  restart,
	input  wire  logic signed [sgrg_pkg::COORD_W-1:0]   start_x,
	input  wire  logic signed [sgrg_pkg::COORD_W-1:0]   start_y,
	// square requests
	output logic                                        out_valid,
	input  wire  logic                                  out_stall,
	output logic signed [sgrg_pkg::COORD_W-1:0]         rect_left,
	output logic signed [sgrg_pkg::COORD_W-1:0]         rect_top,
	output logic signed [sgrg_pkg::COORD_W-1:0]         rect_right,
	output logic signed [sgrg_pkg::COORD_W-1:0]         rect_bottom,
	output logic [sgrg_pkg::COLOR_W-1:0]                rect_color,
	output logic                                        last_of_char
);

	localparam int CW = COORD_BITS;
	localparam int OW = sgrg_pkg::OFS_W;
	localparam logic [CW-1:0] ONE = CW'(1);

	// configuration registers
	logic [sgrg_pkg::SCALE_W-1:0] scale_q;
	logic [sgrg_pkg::COLOR_W-1:0] color_q;
	logic [sgrg_pkg::SCALE_W-1:0] s_eff;

	// input stage
	logic                   s1_valid_q;
	sgrg_pkg::glyph_t       glyph_s1;
	logic                   restart_s1;
	logic [CW-1:0]          start_x_s1;
	logic [CW-1:0]          start_y_s1;

	// pen memory
	logic [2*CW-1:0]        pen_mem [1];
	logic                   pen_vld_q;
	logic [2*CW-1:0]        pen_rd_q;
	logic                   pen_we;
	logic [2*CW-1:0]        pen_wdata;
	logic [CW-1:0]          base_x;
	logic [CW-1:0]          base_y;
	logic [OW-1:0]          pitch;

	// dot scanner
	sgrg_pkg::glyph_t       mask_q;
	sgrg_pkg::glyph_t       mask_rest;
	logic [CW-1:0]          px_q;
	logic [CW-1:0]          py_q;
	logic [sgrg_pkg::ROW_IDX_W-1:0] row_sel;
	logic [sgrg_pkg::COL_IDX_W-1:0] bit_sel;
	logic [sgrg_pkg::COL_IDX_W-1:0] col_sel;
	logic [OW-1:0]          dx;
	logic [OW-1:0]          dy;
	logic [CW-1:0]          x0;
	logic [CW-1:0]          y0;
	logic [CW-1:0]          x1;
	logic [CW-1:0]          y1;
	logic                   out_ready;
	logic                   emit;
	logic                   scan_free;
	logic                   load;
	logic                   in_accept;

	// output register
	logic                   out_valid_q;
	logic [sgrg_pkg::COORD_W-1:0] left_q;
	logic [sgrg_pkg::COORD_W-1:0] top_q;
	logic [sgrg_pkg::COORD_W-1:0] right_q;
	logic [sgrg_pkg::COORD_W-1:0] bottom_q;
	logic [sgrg_pkg::COLOR_W-1:0] color_out_q;
	logic                   last_q;

	// take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= sgrg_pkg::SCALE_RST;
			color_q <= sgrg_pkg::COLOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sgrg_pkg::CFG_PIXEL_SCALE: scale_q <= cfg_data[sgrg_pkg::SCALE_W-1:0];
				sgrg_pkg::CFG_DRAW_COLOR:  color_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// treat a zero scale as one
	assign s_eff = (scale_q == '0) ? sgrg_pkg::SCALE_W'(1) : scale_q;

	// pick the next dot: topmost non-empty row, leftmost set bit in it
	always_comb begin
		row_sel = '0;
		bit_sel = '0;
		for (int r = sgrg_pkg::GLYPH_ROWS - 1; r >= 0; r--) begin
			if (mask_q[r] != '0) row_sel = sgrg_pkg::ROW_IDX_W'(r);
		end
		for (int b = 0; b < sgrg_pkg::GLYPH_COLS; b++) begin
			if (mask_q[row_sel][b]) bit_sel = sgrg_pkg::COL_IDX_W'(b);
		end
		col_sel = sgrg_pkg::COL_IDX_W'(sgrg_pkg::GLYPH_COLS - 1) - bit_sel;
		mask_rest = mask_q;
		mask_rest[row_sel][bit_sel] = 1'b0;
	end

	// square corners of the chosen dot
	assign dx = OW'(col_sel) * OW'(s_eff);
	assign dy = OW'(row_sel) * OW'(s_eff);
	assign x0 = px_q + CW'(dx);
	assign y0 = py_q + CW'(dy);
	assign x1 = x0 + CW'(s_eff) - ONE;
	assign y1 = y0 + CW'(s_eff) - ONE;

	// handshake between the stages
	assign out_ready = !out_valid_q || !out_stall;
	assign emit      = (mask_q != '0) && out_ready;
	assign scan_free = (mask_q == '0) || (emit && (mask_rest == '0));
	assign load      = s1_valid_q && scan_free;
	assign in_stall  = s1_valid_q && !load;
	assign in_accept = in_valid && !in_stall;

	// input stage: register the request and read the glyph table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (load) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			glyph_s1   <= sgrg_pkg::glyph_rom(sgrg_pkg::glyph_index(char_code));
			restart_s1 <= restart;
			start_x_s1 <= CW'(start_x);
			start_y_s1 <= CW'(start_y);
		end
	end

	// pen base for the character entering the scanner, and the advanced pen
	assign base_x    = restart_s1 ? start_x_s1 : pen_rd_q[CW-1:0];
	assign base_y    = restart_s1 ? start_y_s1 : pen_rd_q[2*CW-1:CW];
	assign pitch     = OW'(sgrg_pkg::CELL_PITCH) * OW'(s_eff);
	assign pen_we    = load;
	assign pen_wdata = {base_y, base_x + CW'(pitch)};

	// pen memory write
	always_ff @(posedge clk) begin
		if (pen_we) begin
			pen_mem[0] <= pen_wdata;
		end
	end

	// pen memory read, forward a same-cycle write, read zero before the first write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_vld_q <= 1'b0;
			pen_rd_q  <= '0;
		end else begin
			if (pen_we) pen_vld_q <= 1'b1;
			if (pen_we) begin
				pen_rd_q <= pen_wdata;
			end else if (pen_vld_q) begin
				pen_rd_q <= pen_mem[0];
			end else begin
				pen_rd_q <= '0;
			end
		end
	end

	// dot scanner: load a new glyph or drop the dot just sent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= glyph_s1;
		end else if (emit) begin
			mask_q <= mask_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			px_q <= base_x;
			py_q <= base_y;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			left_q      <= sgrg_pkg::COORD_W'(x0);
			top_q       <= sgrg_pkg::COORD_W'(y0);
			right_q     <= sgrg_pkg::COORD_W'(x1);
			bottom_q    <= sgrg_pkg::COORD_W'(y1);
			color_out_q <= color_q;
			last_q      <= (mask_rest == '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign rect_left    = left_q;
	assign rect_top     = top_q;
	assign rect_right   = right_q;
	assign rect_bottom  = bottom_q;
	assign rect_color   = color_out_q;
	assign last_of_char = last_q;

	// pen read returns what was written the cycle before
	a_pen_forward: assert property (@(posedge clk) disable iff (!arst_n)
		pen_we |=> (pen_rd_q == $past(pen_wdata)))
		else $error("pen read missed a forwarded write");

	// a loaded glyph with dots leaves the scanner busy
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(load && (glyph_s1 != '0)) |=> (mask_q != '0))
		else $error("scanner idle after loading a glyph with dots");

	// the final dot of a character is flagged as such
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && (mask_rest == '0)) |=> (out_valid && last_of_char))
		else $error("final square not flagged");

	// no new character enters while the scanner still owns dots it cannot finish
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(mask_q != '0 && !emit) |-> !load)
		else $error("glyph loaded over pending dots");

endmodule

`default_nettype wire
